/* rtl/indexed_list_engine_defines.svh */
// Assertion macros used by the list engine top level.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ILE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ILE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* rtl/ile_pkg.sv */
`default_nettype none

package ile_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int POS_W        = 8;
   localparam int CMD_W        = 3;
   localparam int DATA_W       = 32;

   localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_BEFORE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

   localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

   // Per-cell control, decoded once in the top level for each cell.
   typedef struct packed {
      logic take_value;   // load the broadcast value
      logic take_prev;    // move up: copy the cell toward the head
      logic take_next;    // move down: copy the cell toward the tail
      logic snap_load;    // copy the entry into the read chain
      logic snap_shift;   // advance the read chain one cell toward the head
   } ile_cell_ctl_type;

endpackage

`default_nettype wire

/* rtl/indexed_list_engine.sv */
`default_nettype none
`include "indexed_list_engine_defines.svh"
// Ordered list engine: holds up to CAPACITY signed 32-bit values packed at
// positions 0 .. count-1 in a row of cells, one value per cell.
// Input channel: an item (req_command, req_position, req_item_value) is
// taken at a rising edge with start high and busy low. Commands: read,
// insert at head, insert at tail, insert before a position, delete.
// Result channel: each item gives exactly one result on rsp_read_value,
// rsp_ok and rsp_count_now, shown for one cycle with rsp_valid high. The
// receiver cannot stall; a result must be taken in the cycle it is shown.
// Inserts, deletes, rejected commands and out-of-range reads: the result
// shows in the cycle after the accepting edge and busy never rises, so a
// new item can follow every cycle.
// In-range reads: the whole list is copied into a read chain and shifted
// one cell toward the head per cycle until the wanted entry reaches cell
// 0; the result is then registered and shown, and busy is high
// meanwhile, so no new item is taken until the read ends.
// Reset (synchronous, active high) empties the list and drops any read in
// progress; stored values are not cleared and are never read unwritten.
module indexed_list_engine #(
   parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [ile_pkg::CMD_W-1:0]          req_command,
   input  wire logic [ile_pkg::POS_W-1:0]          req_position,
   input  wire logic signed [ile_pkg::DATA_W-1:0]  req_item_value,
   output logic                                    rsp_valid,
   output logic signed [ile_pkg::DATA_W-1:0]       rsp_read_value,
   output logic                                    rsp_ok,
   output logic [$clog2(CAPACITY+1)-1:0]           rsp_count_now
);
   import ile_pkg::*;

   // count width holds CAPACITY itself; position compares use the wider
   // of the count and the position field
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [POS_W-1:0]          remain_ff, remain_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                      rsp_ok_ff, rsp_ok_in;
   logic [CW-1:0]             rsp_count_ff, rsp_count_in;

   logic                      accept;
   logic [AW-1:0]             pos_ext;
   logic [AW-1:0]             cnt_ext;
   logic                      full;
   logic                      rd_hit;
   logic                      ins_go;
   logic                      del_go;
   logic [AW-1:0]             ins_at;
   logic                      cmd_ok;
   logic signed [DATA_W-1:0]  cmd_value;
   logic                      snap_shift;

   logic signed [DATA_W-1:0]  entry_q [CAPACITY];
   logic signed [DATA_W-1:0]  snap_q  [CAPACITY];

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign pos_ext = AW'(req_position);
   assign cnt_ext = AW'(count_ff);
   assign full    = (count_ff == CW'(CAPACITY));

   // Decode the command against the current count.
   always_comb begin
      rd_hit    = 1'b0;
      ins_go    = 1'b0;
      del_go    = 1'b0;
      ins_at    = '0;
      cmd_ok    = 1'b0;
      cmd_value = '0;
      case (req_command)
         CMD_READ: begin
            // out of range answers at once; a hit goes through the read chain
            rd_hit    = accept && (pos_ext < cnt_ext);
            cmd_value = READ_MISS;
         end
         CMD_HEAD: begin
            ins_at = '0;
            cmd_ok = !full;
         end
         CMD_TAIL: begin
            ins_at = cnt_ext;
            cmd_ok = !full;
         end
         CMD_BEFORE: begin
            ins_at = pos_ext;
            cmd_ok = !full && (pos_ext <= cnt_ext);
         end
         CMD_DELETE: begin
            cmd_ok = (pos_ext < cnt_ext);
            del_go = accept && cmd_ok;
         end
         default: begin
            cmd_ok = 1'b0;
         end
      endcase
      ins_go = accept && cmd_ok && !del_go &&
               ((req_command == CMD_HEAD) || (req_command == CMD_TAIL) ||
                (req_command == CMD_BEFORE));
   end

   assign snap_shift = (state_ff == ST_SCAN) && (remain_ff != '0);

   // Cell row: entries shift toward the tail on insert and toward the head
   // on delete; the read chain shifts toward cell 0 during a scan.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [AW-1:0] IDX = AW'(i);
      ile_cell_ctl_type        ctl;
      logic signed [DATA_W-1:0] prev_entry;
      logic signed [DATA_W-1:0] next_entry;
      logic signed [DATA_W-1:0] next_snap;

      assign ctl.take_value = ins_go && (IDX == ins_at);
      assign ctl.take_prev  = ins_go && (IDX > ins_at);
      assign ctl.take_next  = del_go && (IDX >= pos_ext);
      assign ctl.snap_load  = rd_hit;
      assign ctl.snap_shift = snap_shift;

      if (i == 0) begin : g_head
         assign prev_entry = '0;
      end else begin : g_body
         assign prev_entry = entry_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_entry = '0;
         assign next_snap  = '0;
      end else begin : g_link
         assign next_entry = entry_q[i+1];
         assign next_snap  = snap_q[i+1];
      end

      ile_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .value_in    (req_item_value),
         .prev_entry  (prev_entry),
         .next_entry  (next_entry),
         .next_snap   (next_snap),
         .entry_value (entry_q[i]),
         .snap_value  (snap_q[i])
      );
   end

   // Sequencer: answer directly, or hold busy while the read chain advances.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (rd_hit) begin
                  state_in  = ST_SCAN;
                  remain_in = req_position;
               end else begin
                  if (ins_go) begin
                     count_in = count_ff + CW'(1);
                  end else if (del_go) begin
                     count_in = count_ff - CW'(1);
                  end
                  rsp_valid_in = 1'b1;
                  rsp_value_in = cmd_value;
                  rsp_ok_in    = cmd_ok;
                  rsp_count_in = count_in;
               end
            end
         end
         ST_SCAN: begin
            if (remain_ff == '0) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_value_in = snap_q[0];
               rsp_ok_in    = 1'b1;
               rsp_count_in = count_ff;
            end else begin
               remain_in = remain_ff - POS_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      remain_ff    <= remain_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_count_now  = rsp_count_ff;

   // Count never passes the capacity.
   `ILE_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   // Any item that skips the read chain answers in the next cycle.
   `ILE_ASSERT_NEXT(a_direct_answer, clock, reset, accept && !rd_hit, rsp_valid)
   // The list does not change while a read scan is running.
   `ILE_ASSERT_NEXT(a_scan_stable, clock, reset, state_ff == ST_SCAN, $stable(count_ff))
   // No result is shown while the scan still has cells to shift.
   `ILE_ASSERT_SAME(a_scan_quiet, clock, reset, snap_shift, !rsp_valid_in)

endmodule

`default_nettype wire

/* rtl/ile_cell.sv */
`default_nettype none

module ile_cell (
   input  wire logic                              clock,
   input  wire ile_pkg::ile_cell_ctl_type         ctl,
   input  wire logic signed [ile_pkg::DATA_W-1:0] value_in,
   input  wire logic signed [ile_pkg::DATA_W-1:0] prev_entry,
   input  wire logic signed [ile_pkg::DATA_W-1:0] next_entry,
   input  wire logic signed [ile_pkg::DATA_W-1:0] next_snap,
   output logic signed [ile_pkg::DATA_W-1:0]      entry_value,
   output logic signed [ile_pkg::DATA_W-1:0]      snap_value
);
   import ile_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic signed [DATA_W-1:0] snap_ff;
   logic signed [DATA_W-1:0] snap_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.take_value) begin
         entry_in = value_in;
      end else if (ctl.take_prev) begin
         entry_in = prev_entry;
      end else if (ctl.take_next) begin
         entry_in = next_entry;
      end

      snap_in = snap_ff;
      if (ctl.snap_load) begin
         snap_in = entry_ff;
      end else if (ctl.snap_shift) begin
         snap_in = next_snap;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      snap_ff  <= snap_in;
   end

   assign entry_value = entry_ff;
   assign snap_value  = snap_ff;

endmodule

`default_nettype wire

/* verif/indexed_list_engine_checker.sv */
`timescale 1ns / 1ps

module indexed_list_engine_checker #(
   parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    busy,
   input  logic [ile_pkg::CMD_W-1:0]               req_command,
   input  logic [ile_pkg::POS_W-1:0]               req_position,
   input  logic signed [ile_pkg::DATA_W-1:0]       req_item_value,
   input  logic                                    rsp_valid,
   input  logic signed [ile_pkg::DATA_W-1:0]       rsp_read_value,
   input  logic                                    rsp_ok,
   input  logic [$clog2(CAPACITY+1)-1:0]           rsp_count_now,
   output int                                      error_count,
   output int                                      pending_count,
   output int                                      results_checked
);
   import ile_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic                     ok;
      logic [CNT_W-1:0]         count_now;
   } list_result_type;

   logic signed [DATA_W-1:0] list_cells [CAPACITY];
   int                       list_len = 0;
   list_result_type          expected_results [$];
   int                       errors = 0;
   int                       checked = 0;

   // Open a gap at the given position and drop the value into it.
   function automatic logic insert_at(int at, logic signed [DATA_W-1:0] value);
      if (list_len >= CAPACITY || at > list_len) return 1'b0;
      for (int i = list_len; i > at; i--) list_cells[i] = list_cells[i-1];
      list_cells[at] = value;
      list_len++;
      return 1'b1;
   endfunction

   function automatic list_result_type apply_list_command(logic [CMD_W-1:0] cmd,
                                                          logic [POS_W-1:0] pos,
                                                          logic signed [DATA_W-1:0] value);
      list_result_type res;
      res.read_value = '0;
      res.ok         = 1'b0;
      case (cmd)
         CMD_READ: begin
            if (int'(pos) < list_len) begin
               res.read_value = list_cells[pos];
               res.ok         = 1'b1;
            end else begin
               res.read_value = READ_MISS;
            end
         end
         CMD_HEAD:   res.ok = insert_at(0, value);
         CMD_TAIL:   res.ok = insert_at(list_len, value);
         CMD_BEFORE: res.ok = insert_at(int'(pos), value);
         CMD_DELETE: begin
            if (int'(pos) < list_len) begin
               // close the gap toward the head
               for (int i = int'(pos); i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
               list_len--;
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      res.count_now = CNT_W'(list_len);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      list_result_type want;
      if (reset) begin
         list_len = 0;
         expected_results.delete();
      end else begin
         // compare first: a result never belongs to an item taken at the same edge
         if (rsp_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: result with no item waiting: read_value %0d ok %0b count_now %0d",
                        $time, rsp_read_value, rsp_ok, rsp_count_now);
            end else begin
               want = expected_results.pop_front();
               checked++;
               if (rsp_read_value !== want.read_value) begin
                  errors++;
                  $display("%0t: read_value mismatch: expected %0d, actual %0d",
                           $time, want.read_value, rsp_read_value);
               end
               if (rsp_ok !== want.ok) begin
                  errors++;
                  $display("%0t: ok mismatch: expected %0b, actual %0b",
                           $time, want.ok, rsp_ok);
               end
               if (rsp_count_now !== want.count_now) begin
                  errors++;
                  $display("%0t: count_now mismatch: expected %0d, actual %0d",
                           $time, want.count_now, rsp_count_now);
               end
            end
         end else if (rsp_valid !== 1'b0) begin
            errors++;
            $display("%0t: rsp_valid unknown: expected 0 or 1, actual %b", $time, rsp_valid);
         end
         if (start === 1'b1 && busy === 1'b0)
            expected_results.push_back(apply_list_command(req_command, req_position,
                                                          req_item_value));
      end
      error_count     <= errors;
      pending_count   <= expected_results.size();
      results_checked <= checked;
   end

endmodule

/* verif/indexed_list_engine_tb.sv */
`timescale 1ns / 1ps

module indexed_list_engine_tb;
   import ile_pkg::*;

   localparam int LIST_CAP    = CAPACITY_DEF;
   localparam int CNT_W       = $clog2(LIST_CAP + 1);
   localparam int CYCLE_LIMIT = 400_000;
   localparam int NUM_SEGS    = 11;
   localparam int SEG_ITEMS   = 50;

   // Codes past delete do nothing; name the first of them.
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;

   typedef enum logic [1:0] {MIX_OPS, FILL_OPS, DRAIN_OPS} op_bias_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [CMD_W-1:0]         req_command = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_item_value = '0;
   logic                     busy;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic                     rsp_ok;
   logic [CNT_W-1:0]         rsp_count_now;

   int fails;
   int pending;
   int checked;
   int cycle_count = 0;

   // Rough tally of what the stimulus did, for the closing summary.
   int shadow_len   = 0;
   int items_sent   = 0;
   int reads_sent   = 0;
   int inserts_sent = 0;
   int deletes_sent = 0;
   int spare_sent   = 0;
   int full_rejects = 0;
   int list_empties = 0;

   indexed_list_engine #(.CAPACITY(LIST_CAP)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_ok         (rsp_ok),
      .rsp_count_now  (rsp_count_now)
   );

   indexed_list_engine_checker #(.CAPACITY(LIST_CAP)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_ok          (rsp_ok),
      .rsp_count_now   (rsp_count_now),
      .error_count     (fails),
      .pending_count   (pending),
      .results_checked (checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: end the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at cycle %0d with %0d results outstanding", cycle_count, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offer one item and hold it until the block takes it. Idle cycles drop
   // start first; with no idling start stays high from item to item, so it
   // is never lowered and raised in the same step.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] value, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_command    <= cmd;
      req_position   <= pos;
      req_item_value <= value;
      // busy seen here is its value before the edge, which decides acceptance
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      case (cmd)
         CMD_READ: reads_sent++;
         CMD_HEAD, CMD_TAIL, CMD_BEFORE: begin
            inserts_sent++;
            if (shadow_len == LIST_CAP) full_rejects++;
            else if (cmd != CMD_BEFORE || int'(pos) <= shadow_len) shadow_len++;
         end
         CMD_DELETE: begin
            deletes_sent++;
            if (int'(pos) < shadow_len) begin
               shadow_len--;
               if (shadow_len == 0) list_empties++;
            end
         end
         default: spare_sent++;
      endcase
   endtask

   initial begin
      logic [CMD_W-1:0]         cmd;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      int                       r;
      int                       span;
      int                       idle_pct;
      int                       ins_lim;
      int                       read_lim;
      int                       del_lim;
      int                       idle_plan [3];
      op_bias_type              bias_plan [NUM_SEGS];
      logic signed [DATA_W-1:0] corner_values [4];

      idle_plan     = '{0, 56, 14};
      // fill to capacity and past it, drain to empty and past it, then refill
      bias_plan     = '{MIX_OPS, FILL_OPS, FILL_OPS, DRAIN_OPS, DRAIN_OPS, MIX_OPS,
                        FILL_OPS, FILL_OPS, MIX_OPS, DRAIN_OPS, DRAIN_OPS};
      corner_values = '{32'sh7FFF_FFFF, 32'sh8000_0000, READ_MISS, 32'sh0};

      // Hold reset at first, then release it for good.
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: commands on an empty list, extremes of the value field,
      // boundary positions, unused codes and a drain back to empty.
      send_item(CMD_READ,   8'd0,   32'sh0, 0);          // read of an empty list
      send_item(CMD_DELETE, 8'd0,   32'sh0, 0);          // delete from an empty list
      send_item(CMD_BEFORE, 8'd1,   32'sh1234_5678, 0);  // insert past the tail
      send_item(CMD_BEFORE, 8'd0,   32'sh7FFF_FFFF, 0);  // insert at the tail position
      send_item(CMD_HEAD,   8'd255, 32'sh8000_0000, 0);
      send_item(CMD_TAIL,   8'd255, READ_MISS, 0);
      send_item(CMD_TAIL,   8'd0,   32'sh0, 0);
      send_item(CMD_BEFORE, 8'd2,   32'sh5555_5555, 0);
      send_item(CMD_BEFORE, 8'd5,   32'shAAAA_AAAA, 0);  // appends: position equals count
      send_item(CMD_BEFORE, 8'd7,   32'sh0BAD_0BAD, 0);  // one past count
      send_item(CMD_READ,   8'd0,   32'sh0, 0);
      send_item(CMD_READ,   8'd5,   READ_MISS, 0);
      send_item(CMD_READ,   8'd6,   32'sh0, 0);          // read at count
      send_item(CMD_READ,   8'd255, 32'sh0, 0);
      send_item(CMD_DELETE, 8'd6,   32'sh0, 0);          // delete at count
      send_item(CMD_DELETE, 8'd255, READ_MISS, 0);
      send_item(CMD_DELETE, 8'd0,   32'sh0, 0);
      send_item(CMD_DELETE, 8'd4,   32'sh0, 0);          // delete the tail
      send_item(CMD_DELETE, 8'd1,   32'sh0, 0);
      send_item(CMD_SPARE_FIRST,        8'd255, READ_MISS, 0);
      send_item(CMD_SPARE_FIRST + 3'd1, 8'd0,   32'sh7FFF_FFFF, 0);
      send_item(CMD_SPARE_FIRST + 3'd2, 8'd1,   32'sh8000_0000, 0);
      repeat (3) send_item(CMD_DELETE, 8'd0, 32'sh0, 0);  // drain to empty
      send_item(CMD_TAIL,   8'd0,   32'sh0F0F_0F0F, 0);  // refill the emptied list
      send_item(CMD_READ,   8'd0,   32'sh0, 0);

      // Random: segments that lean toward filling, draining or a mix, each
      // under one of the sender idle rates.
      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         idle_pct = idle_plan[seg % 3];
         case (bias_plan[seg])
            FILL_OPS:  begin ins_lim = 80; read_lim = 90; del_lim = 96; end
            DRAIN_OPS: begin ins_lim = 10; read_lim = 22; del_lim = 96; end
            default:   begin ins_lim = 35; read_lim = 65; del_lim = 92; end
         endcase
         for (int n = 0; n < SEG_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < ins_lim) begin
               case ($urandom_range(2))
                  0:       cmd = CMD_HEAD;
                  1:       cmd = CMD_TAIL;
                  default: cmd = CMD_BEFORE;
               endcase
            end else if (r < read_lim) begin
               cmd = CMD_READ;
            end else if (r < del_lim) begin
               cmd = CMD_DELETE;
            end else begin
               cmd = CMD_SPARE_FIRST + CMD_W'($urandom_range(2));
            end
            // Mostly in-range positions; the rest anywhere in the field.
            span = (cmd == CMD_BEFORE) ? shadow_len + 1 : shadow_len;
            if (span > 0 && $urandom_range(99) < 88) pos = POS_W'($urandom_range(span - 1));
            else pos = POS_W'($urandom_range(255));
            if ($urandom_range(9) == 0) value = corner_values[$urandom_range(3)];
            else value = $urandom;
            send_item(cmd, pos, value, idle_pct);
         end
      end

      // Drop start at the last accepting edge, drain results, then idle a while.
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LIST_CAP + 4) @(posedge clock);

      $display("Sent %0d items: %0d reads, %0d inserts, %0d deletes, %0d unused codes; %0d checked",
               items_sent, reads_sent, inserts_sent, deletes_sent, spare_sent, checked);
      $display("Inserts refused on a full list: %0d; list drained to empty %0d times",
               full_rejects, list_empties);
      if (fails == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
